>>> src/ptl_pkg.sv
// shared types and constants for the packed trie prefix lookup unit
// no dependencies
package ptl_pkg;

  localparam int NODE_COUNT_DEF = 1048576;
  localparam int CHILD_W        = 24;
  localparam int IDX_W          = CHILD_W + 1;
  localparam int SCAN_LIMIT     = 34;
  localparam int CNT_W          = $clog2(SCAN_LIMIT);

  localparam logic [7:0] BYTE_NEWLINE = 8'd10;
  localparam logic [7:0] BYTE_HYPHEN  = 8'd45;
  localparam logic [7:0] BYTE_LEAD_D0 = 8'd208;
  localparam logic [7:0] BYTE_LEAD_D1 = 8'd209;
  localparam logic [7:0] BYTE_D0_BASE = 8'd176;
  localparam logic [7:0] BYTE_D1_OFFS = 8'd112;
  localparam logic [7:0] BYTE_YO      = 8'd145;
  localparam logic [5:0] CODE_YO      = 6'd32;
  localparam logic [5:0] CODE_HYPHEN  = 6'd33;

  typedef enum logic [1:0] {
    STATUS_FOUND   = 2'd0,
    STATUS_LOST    = 2'd1,
    STATUS_INVALID = 2'd2
  } ptl_status_t;

  typedef enum logic [1:0] {
    LEAD_NONE = 2'd0,
    LEAD_D0   = 2'd1,
    LEAD_D1   = 2'd2
  } ptl_lead_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHILD,
    ST_SCAN,
    ST_FINISH
  } ptl_state_t;

  typedef struct packed {
    logic node_wr;
    logic take_byte;
    logic load_child;
    logic step;
    logic set_match;
    logic set_lost;
    logic emit;
  } ptl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_newline;
    logic want_descend;
    logic child_bad;
    logic sym_match;
    logic run_end;
    logic out_busy;
  } ptl_sts_t;

endpackage

>>> src/ptl_ctrl.sv
// controller state machine: request handshake and descent sequencing
// depends on ptl_pkg
module ptl_ctrl import ptl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ptl_sts_t sts,
  output ptl_cmd_t cmd
);

  ptl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (sts.is_write) begin
            cmd.node_wr = 1'b1;
          end else begin
            cmd.take_byte = 1'b1;
            if (sts.is_newline) begin
              state_nxt = ST_FINISH;
            end else if (sts.want_descend) begin
              state_nxt = ST_CHILD;
            end
          end
        end
      end
      ST_CHILD: begin
        if (sts.child_bad) begin
          cmd.set_lost = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.load_child = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.sym_match) begin
          cmd.set_match = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (sts.run_end) begin
          cmd.set_lost = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/ptl_datapath.sv
// datapath: node memory, byte decoder, query registers and result register
// depends on ptl_pkg
module ptl_datapath import ptl_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ptl_cmd_t    cmd,
  output ptl_sts_t    sts,
  input  logic        in_opcode,
  input  logic [19:0] in_node_addr,
  input  logic [31:0] in_node_word,
  input  logic [7:0]  in_query_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_word_ends,
  output logic [19:0] out_matched_node,
  output logic [23:0] out_child_start
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [IDX_W-1:0] NODE_LIMIT = IDX_W'(NODE_COUNT);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(SCAN_LIMIT - 1);

  logic [31:0] mem [NODE_COUNT];
  logic [31:0] rdata_r;

  logic [AW-1:0]    cur_r;
  logic             lost_r;
  logic             bad_r;
  ptl_lead_t        lead_r;
  logic [5:0]       code_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] cnt_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic             out_word_ends_r;
  logic [19:0]      out_matched_node_r;
  logic [23:0]      out_child_start_r;

  logic [CHILD_W-1:0] child;
  logic [IDX_W-1:0]   child_ext;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   wr_ext;
  logic [23:0]        cur_ext;
  logic [IDX_W-1:0]   rd_idx;
  logic [23:0]        wr_idx;

  ptl_lead_t  lead_nxt;
  logic       bad_nxt;
  logic       desc;
  logic [5:0] code_nxt;

  assign child     = rdata_r[CHILD_W-1:0];
  assign child_ext = IDX_W'(child);
  assign idx_inc   = idx_r + IDX_W'(1);
  assign wr_ext    = IDX_W'(in_node_addr);
  assign wr_idx    = 24'(in_node_addr);
  assign cur_ext   = 24'(cur_r);

  always_comb begin
    if (cmd.load_child) begin
      rd_idx = child_ext;
    end else if (cmd.step) begin
      rd_idx = idx_inc;
    end else begin
      rd_idx = IDX_W'(cur_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.node_wr && (wr_ext < NODE_LIMIT)) begin
      mem[wr_idx[AW-1:0]] <= in_node_word;
    end
    rdata_r <= mem[rd_idx[AW-1:0]];
  end

  always_comb begin
    lead_nxt = lead_r;
    bad_nxt  = bad_r;
    desc     = 1'b0;
    code_nxt = code_r;
    if (!bad_r) begin
      case (lead_r)
        LEAD_D0: begin
          lead_nxt = LEAD_NONE;
          if (in_query_byte inside {[8'd176:8'd191]}) begin
            desc     = 1'b1;
            code_nxt = 6'(in_query_byte - BYTE_D0_BASE);
          end else begin
            bad_nxt = 1'b1;
          end
        end
        LEAD_D1: begin
          lead_nxt = LEAD_NONE;
          if (in_query_byte inside {[8'd128:8'd143]}) begin
            desc     = 1'b1;
            code_nxt = 6'(in_query_byte - BYTE_D1_OFFS);
          end else if (in_query_byte == BYTE_YO) begin
            desc     = 1'b1;
            code_nxt = CODE_YO;
          end else begin
            bad_nxt = 1'b1;
          end
        end
        default: begin
          if (in_query_byte == BYTE_HYPHEN) begin
            desc     = 1'b1;
            code_nxt = CODE_HYPHEN;
          end else if (in_query_byte == BYTE_LEAD_D0) begin
            lead_nxt = LEAD_D0;
          end else if (in_query_byte == BYTE_LEAD_D1) begin
            lead_nxt = LEAD_D1;
          end else begin
            bad_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  assign sts.is_write     = !in_opcode;
  assign sts.is_newline   = (in_query_byte == BYTE_NEWLINE);
  assign sts.want_descend = desc && !lost_r;
  assign sts.child_bad    = (child == '0) || (child_ext >= NODE_LIMIT);
  assign sts.sym_match    = (rdata_r[31:26] == code_r);
  assign sts.run_end      = !rdata_r[24] || (cnt_r == CNT_LAST) || (idx_inc >= NODE_LIMIT);
  assign sts.out_busy     = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      lost_r <= 1'b0;
      bad_r  <= 1'b0;
      lead_r <= LEAD_NONE;
    end else begin
      if (cmd.take_byte) begin
        if (sts.is_newline) begin
          if (lead_r != LEAD_NONE) begin
            bad_r <= 1'b1;
          end
        end else begin
          lead_r <= lead_nxt;
          bad_r  <= bad_nxt;
        end
      end
      if (cmd.set_lost) begin
        lost_r <= 1'b1;
      end
      if (cmd.set_match) begin
        cur_r <= idx_r[AW-1:0];
      end
      if (cmd.emit) begin
        cur_r  <= '0;
        lost_r <= 1'b0;
        bad_r  <= 1'b0;
        lead_r <= LEAD_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      code_r <= code_nxt;
    end
    if (cmd.load_child) begin
      idx_r <= child_ext;
      cnt_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_inc;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (bad_r) begin
        out_status_r       <= STATUS_INVALID;
        out_word_ends_r    <= 1'b0;
        out_matched_node_r <= '0;
        out_child_start_r  <= '0;
      end else if (lost_r) begin
        out_status_r       <= STATUS_LOST;
        out_word_ends_r    <= 1'b0;
        out_matched_node_r <= '0;
        out_child_start_r  <= '0;
      end else begin
        out_status_r       <= STATUS_FOUND;
        out_word_ends_r    <= rdata_r[25];
        out_matched_node_r <= cur_ext[19:0];
        out_child_start_r  <= rdata_r[23:0];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_word_ends    = out_word_ends_r;
  assign out_matched_node = out_matched_node_r;
  assign out_child_start  = out_child_start_r;

endmodule

>>> src/packed_trie_prefix_lookup_unit.sv
// packed trie prefix lookup: node writes and query bytes that need no descent are taken in idle
// a letter that descends reads the parent at acceptance, then its child index, then each
// examined sibling in turn on the single read port, at most 34; no new byte is taken meanwhile
// a newline result is registered from the finish state, held while the prior result stalls
// reset clears the query state and the result valid flag; the node memory keeps its contents
// depends on ptl_pkg, ptl_ctrl, ptl_datapath
module packed_trie_prefix_lookup_unit import ptl_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [19:0] in_node_addr,
  input  logic [31:0] in_node_word,
  input  logic [7:0]  in_query_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_word_ends,
  output logic [19:0] out_matched_node,
  output logic [23:0] out_child_start
);

  ptl_cmd_t cmd;
  ptl_sts_t sts;

  ptl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptl_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_node_addr     (in_node_addr),
    .in_node_word     (in_node_word),
    .in_query_byte    (in_query_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_word_ends    (out_word_ends),
    .out_matched_node (out_matched_node),
    .out_child_start  (out_child_start)
  );

endmodule

>>> verif/packed_trie_prefix_lookup_unit_tb.sv
// testbench for packed_trie_prefix_lookup_unit: loads trie node words, walks queries through them
// and checks every lookup result against a shadow trie held in a small scoreboard class
// depends on ptl_pkg and the packed_trie_prefix_lookup_unit rtl
`timescale 1ns / 1ps

module packed_trie_prefix_lookup_unit_tb;
  import ptl_pkg::*;

  localparam int NODE_COUNT = NODE_COUNT_DEF;
  localparam int TOP_BASE = NODE_COUNT - 64;
  localparam int LOW_SPAN = 128;
  localparam int LONG_RUN = 40;
  localparam int ITEM_COUNT = 1000;
  localparam logic [5:0] CODE_D1_FIRST = 6'd16;
  localparam logic [5:0] CODE_NONE = 6'd63;
  localparam logic [7:0] BYTE_BAD = 8'hFF;

  typedef struct packed {
    ptl_status_t status;
    logic word_ends;
    logic [19:0] node;
    logic [23:0] child;
  } lookup_result_t;

  class trie_lookup_scoreboard;
    bit [31:0] node_mem [int unsigned];
    bit [19:0] cur_node;
    bit lost;
    bit bad;
    ptl_lead_t lead = LEAD_NONE;
    lookup_result_t expected_lookups[$];
    int errors;

    function bit [31:0] node_at(int unsigned idx);
      return node_mem.exists(idx) ? node_mem[idx] : 32'd0;
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction

    function void follow_code(bit [5:0] code);
      bit [31:0] w;
      int unsigned idx;
      if (lost || bad) return;
      w = node_at(cur_node);
      idx = 32'(w[23:0]);
      if (idx == 0) begin
        lost = 1'b1;
        return;
      end
      for (int k = 0; k < SCAN_LIMIT; k++) begin
        if (idx >= NODE_COUNT) break;
        w = node_at(idx);
        if (w[31:26] == code) begin
          cur_node = idx[19:0];
          return;
        end
        if (!w[24]) break;
        idx++;
      end
      lost = 1'b1;
    endfunction

    function void note_request(logic op, logic [19:0] addr, logic [31:0] word,
                               logic [7:0] qb);
      bit [31:0] w;
      lookup_result_t r;
      if (!op) begin
        if (addr < NODE_COUNT) node_mem[addr] = word;
        return;
      end
      if (qb == BYTE_NEWLINE) begin
        if (lead != LEAD_NONE) bad = 1'b1;
        if (bad) r = '{STATUS_INVALID, 1'b0, 20'd0, 24'd0};
        else if (lost) r = '{STATUS_LOST, 1'b0, 20'd0, 24'd0};
        else begin
          w = node_at(cur_node);
          r = '{STATUS_FOUND, w[25], cur_node, w[23:0]};
        end
        expected_lookups.push_back(r);
        cur_node = '0;
        lost = 1'b0;
        bad = 1'b0;
        lead = LEAD_NONE;
        return;
      end
      if (bad) return;
      case (lead)
        LEAD_D0: begin
          lead = LEAD_NONE;
          if (qb >= BYTE_D0_BASE && qb <= BYTE_D0_BASE + 8'd15)
            follow_code(6'(qb - BYTE_D0_BASE));
          else bad = 1'b1;
        end
        LEAD_D1: begin
          lead = LEAD_NONE;
          if (qb >= BYTE_D1_OFFS + 8'(CODE_D1_FIRST) && qb <= BYTE_D1_OFFS + 8'd31)
            follow_code(6'(qb - BYTE_D1_OFFS));
          else if (qb == BYTE_YO) follow_code(CODE_YO);
          else bad = 1'b1;
        end
        default: begin
          if (qb == BYTE_HYPHEN) follow_code(CODE_HYPHEN);
          else if (qb == BYTE_LEAD_D0) lead = LEAD_D0;
          else if (qb == BYTE_LEAD_D1) lead = LEAD_D1;
          else bad = 1'b1;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] st, logic we, logic [19:0] mn, logic [23:0] cs);
      lookup_result_t want;
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d node %0h",
                 $time, st, mn);
        errors++;
        return;
      end
      want = expected_lookups.pop_front();
      compare_field("status", 24'(want.status), 24'(st));
      compare_field("word_ends", 24'(want.word_ends), 24'(we));
      compare_field("matched_node", 24'(want.node), 24'(mn));
      compare_field("child_start", want.child, cs);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic [19:0] in_node_addr = '0;
  logic [31:0] in_node_word = '0;
  logic [7:0] in_query_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic out_word_ends;
  logic [19:0] out_matched_node;
  logic [23:0] out_child_start;

  trie_lookup_scoreboard lookups = new();
  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = 0;
  int stall_left = 0;

  packed_trie_prefix_lookup_unit #(.NODE_COUNT(NODE_COUNT)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_node_addr(in_node_addr),
    .in_node_word(in_node_word),
    .in_query_byte(in_query_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_word_ends(out_word_ends),
    .out_matched_node(out_matched_node),
    .out_child_start(out_child_start)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      lookups.check_result(out_status, out_word_ends, out_matched_node, out_child_start);
  end

  // child pointers inside the node memory only reach written regions, so no unwritten node is ever read
  function automatic logic [31:0] random_node();
    logic [5:0] sym;
    logic word_end;
    logic sib;
    logic [23:0] child;
    case ($urandom_range(0, 9))
      0: child = '0;
      1: child = 24'($urandom_range(NODE_COUNT, 24'hFFFFFF));
      2: child = 24'($urandom_range(TOP_BASE, NODE_COUNT - 1));
      default: child = 24'($urandom_range(1, LOW_SPAN / 2 - 1));
    endcase
    sym = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 33));
    word_end = 1'($urandom_range(0, 1));
    sib = ($urandom_range(0, 9) < 7);
    return {sym, word_end, sib, child};
  endfunction

  function automatic logic [31:0] preset_node(int unsigned idx);
    logic [5:0] sym;
    logic sib;
    logic [23:0] child;
    sym = CODE_NONE;
    sib = 1'b0;
    child = '0;
    if (idx >= TOP_BASE) begin
      sym = 6'((idx - TOP_BASE) % 34);
      sib = 1'b1;
    end else if (idx == 0) begin
      child = 24'd1;
    end else if (idx <= 34) begin
      sym = 6'(idx - 1);
      sib = (idx != 34);
      case (idx)
        1: child = '0;
        2: child = 24'(NODE_COUNT);
        3: child = 24'(NODE_COUNT - 2);
        4: child = 24'(LONG_RUN);
        default: child = 24'd1;
      endcase
    end else if (idx >= LONG_RUN && idx <= LONG_RUN + SCAN_LIMIT) begin
      sib = 1'b1;
      if (idx == LONG_RUN + SCAN_LIMIT - 1) sym = CODE_YO;
      if (idx == LONG_RUN + SCAN_LIMIT) sym = CODE_HYPHEN;
    end
    return {sym, idx[0], sib, child};
  endfunction

  function automatic logic [5:0] pick_code();
    logic [31:0] w;
    int unsigned idx;
    w = lookups.node_at(lookups.cur_node);
    idx = 32'(w[23:0]);
    if (lookups.lost || lookups.bad || idx == 0 || idx >= NODE_COUNT ||
        $urandom_range(0, 9) == 0)
      return 6'($urandom_range(0, 33));
    repeat ($urandom_range(0, 5)) begin
      w = lookups.node_at(idx);
      if (!w[24] || idx + 1 >= NODE_COUNT) break;
      idx++;
    end
    w = lookups.node_at(idx);
    return (w[31:26] <= CODE_HYPHEN) ? w[31:26] : 6'($urandom_range(0, 33));
  endfunction

  task automatic send_request(input logic op, input logic [19:0] addr,
                              input logic [31:0] word, input logic [7:0] qb);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_node_addr <= addr;
    in_node_word <= word;
    in_query_byte <= qb;
    do @(posedge clk); while (in_stall !== 1'b0);
    lookups.note_request(op, addr, word, qb);
    items_sent++;
  endtask

  task automatic send_write(input logic [19:0] addr, input logic [31:0] word);
    send_request(1'b0, addr, word, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_byte(input logic [7:0] qb);
    send_request(1'b1, 20'($urandom), 32'($urandom), qb);
  endtask

  task automatic send_random_write();
    logic [19:0] addr;
    addr = 20'(($urandom_range(0, 3) == 0) ? $urandom_range(TOP_BASE, NODE_COUNT - 1)
                                           : $urandom_range(0, LOW_SPAN - 1));
    send_write(addr, random_node());
  endtask

  task automatic send_letter(input logic [5:0] code);
    if (code < CODE_D1_FIRST) begin
      send_byte(BYTE_LEAD_D0);
      send_byte(BYTE_D0_BASE + 8'(code));
    end else if (code < CODE_YO) begin
      send_byte(BYTE_LEAD_D1);
      send_byte(BYTE_D1_OFFS + 8'(code));
    end else if (code == CODE_YO) begin
      send_byte(BYTE_LEAD_D1);
      send_byte(BYTE_YO);
    end else begin
      send_byte(BYTE_HYPHEN);
    end
  endtask

  task automatic random_query();
    int letters;
    int noise_at;
    int write_at;
    letters = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
    noise_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, letters) : -1;
    write_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, letters) : -1;
    for (int i = 0; i <= letters; i++) begin
      if (i == noise_at) begin
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 255)));
        else begin
          send_byte(($urandom_range(0, 1) == 0) ? BYTE_LEAD_D0 : BYTE_LEAD_D1);
          send_byte(8'($urandom_range(0, 255)));
        end
      end
      if (i == write_at) send_random_write();
      if (i < letters) send_letter(pick_code());
    end
    if ($urandom_range(0, 19) == 0)
      send_byte(($urandom_range(0, 1) == 0) ? BYTE_LEAD_D0 : BYTE_LEAD_D1);
    send_byte(BYTE_NEWLINE);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned a = 0; a < LOW_SPAN; a++) send_write(20'(a), preset_node(a));
    for (int unsigned a = TOP_BASE; a < NODE_COUNT; a++) send_write(20'(a), preset_node(a));

    send_byte(BYTE_NEWLINE);
    // leaf, child past memory, run off the top of memory
    send_letter(6'd0); send_letter(6'd0); send_byte(BYTE_NEWLINE);
    send_letter(6'd1); send_letter(6'd5); send_byte(BYTE_NEWLINE);
    send_letter(6'd2); send_letter(6'd29); send_byte(BYTE_NEWLINE);
    send_letter(6'd2); send_letter(6'd30); send_byte(BYTE_NEWLINE);
    // last examined sibling, then the one past the scan limit
    send_letter(6'd3); send_letter(CODE_YO); send_byte(BYTE_NEWLINE);
    send_letter(6'd3); send_letter(CODE_HYPHEN); send_byte(BYTE_NEWLINE);
    send_letter(6'd15); send_letter(CODE_D1_FIRST); send_letter(6'd31);
    send_letter(CODE_HYPHEN); send_byte(BYTE_NEWLINE);
    send_letter(CODE_YO); send_byte(BYTE_NEWLINE);
    // invalid cases
    send_byte(BYTE_LEAD_D0); send_byte(BYTE_NEWLINE);
    send_byte(BYTE_LEAD_D1); send_byte(BYTE_YO + 8'd1); send_byte(BYTE_NEWLINE);
    send_letter(6'd0); send_letter(6'd0); send_byte(BYTE_BAD); send_byte(BYTE_NEWLINE);
    send_byte(BYTE_LEAD_D0); send_write(20'd99, random_node());
    send_byte(BYTE_D0_BASE + 8'd5); send_byte(BYTE_NEWLINE);

    while (items_sent < ITEM_COUNT) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 3)) send_random_write();
      end else begin
        random_query();
      end
    end

    in_valid <= 1'b0;
    while (lookups.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (lookups.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> packed_trie_prefix_lookup_unit.f
src/ptl_pkg.sv
src/ptl_ctrl.sv
src/ptl_datapath.sv
src/packed_trie_prefix_lookup_unit.sv
verif/packed_trie_prefix_lookup_unit_tb.sv
